// ===== src/lsfa_pkg.sv =====
package lsfa_pkg;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               object_seen;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic               base_pos_ok;
    logic signed [31:0] object_x;
    logic signed [31:0] object_y;
  } lsfa_in_t;

  typedef struct packed {
    logic signed [31:0] drive_x;
    logic signed [31:0] drive_y;
    logic signed [31:0] drive_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic        [16:0] share_out;
    logic        [2:0]  status;
  } lsfa_out_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_ROOT = 2'd2
  } unit_op_t;

  // register indexes
  localparam logic [2:0] REG_EXPECTED = 3'd0;
  localparam logic [2:0] REG_MAXW     = 3'd1;
  localparam logic [2:0] REG_CEILING  = 3'd2;
  localparam logic [2:0] REG_LEVEL    = 3'd3;
  localparam logic [2:0] REG_TRIGGER  = 3'd4;
  localparam logic [2:0] REG_FINAL    = 3'd5;
  localparam logic [2:0] REG_CONTACT  = 3'd6;

  // status codes
  localparam logic [2:0] ST_NO_MARKER  = 3'd0;
  localparam logic [2:0] ST_TOO_FAR    = 3'd1;
  localparam logic [2:0] ST_MARKER_FAR = 3'd2;
  localparam logic [2:0] ST_COMING     = 3'd3;
  localparam logic [2:0] ST_CARRYING   = 3'd4;
  localparam logic [2:0] ST_UNDER      = 3'd5;
  localparam logic [2:0] ST_HOLDING    = 3'd6;

  localparam logic [31:0] GAIN_W    = 32'd6554;
  localparam logic [31:0] GAIN_FAR  = 32'd3277;
  localparam logic [31:0] GAIN_HOLD = 32'd655;
  localparam logic [31:0] GAIN_Z    = 32'd328;
  localparam logic [31:0] DIST_FAR  = 32'd65536;
  localparam logic [31:0] DIST_NEAR = 32'd7864;
  localparam logic [31:0] DIST_HIGH = 32'd13107;
  localparam logic [31:0] DIST_NONE = 32'd6553600;
  localparam logic [16:0] ONE_Q16   = 17'd65536;

endpackage

// ===== src/load_support_force_and_attractor.sv =====
// Load-support controller, one beat per control tick.
// Input channel in_valid/in_ready/in_data carries the sensed force, the
// object offset and the object position; output channel out_valid/
// out_ready/out_data carries the compensating force, the equilibrium
// point, the load share and a status code. Registers are written through
// cfg_we/cfg_addr/cfg_data; the user must write them only while no tick
// is in flight, as the block itself does not enforce it. All products,
// square roots and divisions run on one bit-serial unit. A tick with
// the object not seen and zero expected weight needs the fewest unit
// operations, one with the object seen, deadzone active and lowering in
// progress the most. in_ready is high only while the sequencer is idle.
// The result beat sits in an output register; a new tick is taken while
// it waits, and the next result is held back until the receiver has
// taken the previous one.
// Synchronous reset clears the filters, puts the attractor and held
// object position at rest and loads the register defaults.
module load_support_force_and_attractor import lsfa_pkg::*; #(
  parameter logic signed [31:0] REST_X = 32'sd0,
  parameter logic signed [31:0] REST_Y = 32'sd0,
  parameter logic signed [31:0] REST_Z = 32'sd13107
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lsfa_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lsfa_out_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_SQA   = 20'h00002,
    S_SQB   = 20'h00004,
    S_ROOTD = 20'h00008,
    S_AX    = 20'h00010,
    S_AY    = 20'h00020,
    S_WGT   = 20'h00040,
    S_SHR   = 20'h00080,
    S_SQFX  = 20'h00100,
    S_SQFY  = 20'h00200,
    S_ROOTS = 20'h00400,
    S_DZMX  = 20'h00800,
    S_DZDX  = 20'h01000,
    S_DZMY  = 20'h02000,
    S_DZDY  = 20'h04000,
    S_ZT    = 20'h08000,
    S_BDIV  = 20'h10000,
    S_BMUL  = 20'h20000,
    S_ZM    = 20'h40000,
    S_OUT   = 20'h80000
  } state_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -67'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // configuration
  logic        [30:0] expected_weight, max_weight;
  logic signed [31:0] z_top, z_level;
  logic        [16:0] share_trigger, share_final, share_contact;

  // tick state
  state_t             st;
  logic               launched;
  lsfa_in_t           inr;
  logic               held_prev;
  logic        [30:0] weight_est;
  logic        [16:0] share_est;
  logic signed [31:0] attr_x, attr_y, attr_z, hold_x, hold_y;
  logic        [31:0] obj_dist, side;
  logic        [63:0] tmp;
  logic        [2:0]  stat;
  logic signed [31:0] mv_tx, mv_ty, tgt, dx, dy;
  logic        [31:0] mv_gain;
  logic        [16:0] beta;

  // shared unit
  logic        u_start, u_done;
  unit_op_t    u_op;
  logic [63:0] u_a;
  logic [31:0] u_b;
  logic [64:0] u_res;
  logic signed [32:0] mv;
  logic signed [66:0] prod_s, q16;
  logic        [31:0] root_val;
  logic signed [66:0] w_sum;
  logic        [30:0] w_new, missing;
  logic signed [31:0] z_sum, z_lo;
  logic               unit_state;

  lsfa_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .start  (u_start),
    .op     (u_op),
    .a      (u_a),
    .b      (u_b),
    .done   (u_done),
    .result (u_res)
  );

  // operand select for the current step
  always_comb begin
    u_op = OP_MUL;
    mv   = '0;
    u_a  = '0;
    u_b  = '0;
    unique case (st)
      S_SQA:   begin u_a = {32'd0, abs32(inr.offset_x)}; u_b = abs32(inr.offset_x); end
      S_SQB:   begin u_a = {32'd0, abs32(inr.offset_y)}; u_b = abs32(inr.offset_y); end
      S_ROOTD, S_ROOTS: begin u_op = OP_ROOT; u_a = tmp; end
      S_AX:    begin mv = 33'(mv_tx) - 33'(attr_x); u_b = mv_gain; end
      S_AY:    begin mv = 33'(mv_ty) - 33'(attr_y); u_b = mv_gain; end
      S_WGT:   begin mv = -33'(inr.force_z) - $signed({2'b00, weight_est}); u_b = GAIN_W; end
      S_SHR:   begin
        u_op = OP_DIV;
        u_a  = {17'd0, weight_est, 16'd0};
        u_b  = {1'b0, expected_weight};
      end
      S_SQFX:  begin u_a = {32'd0, abs32(inr.force_x)}; u_b = abs32(inr.force_x); end
      S_SQFY:  begin u_a = {32'd0, abs32(inr.force_y)}; u_b = abs32(inr.force_y); end
      S_DZMX:  begin u_a = {32'd0, abs32(inr.force_x)}; u_b = {1'b0, missing}; end
      S_DZMY:  begin u_a = {32'd0, abs32(inr.force_y)}; u_b = {1'b0, missing}; end
      S_DZDX, S_DZDY: begin u_op = OP_DIV; u_a = tmp; u_b = side; end
      S_BDIV:  begin
        u_op = OP_DIV;
        u_a  = {31'd0, share_est - share_trigger, 16'd0};
        u_b  = {15'd0, share_final - share_trigger};
      end
      S_BMUL:  begin mv = 33'(z_level) - 33'(z_top); u_b = {15'd0, beta}; end
      S_ZM:    begin mv = 33'(tgt) - 33'(attr_z); u_b = GAIN_Z; end
      default: ;
    endcase
    if (st == S_AX || st == S_AY || st == S_WGT || st == S_BMUL || st == S_ZM) begin
      u_a = {31'd0, mv[32] ? 33'(-mv) : 33'(mv)};
    end
  end

  assign unit_state = !(st == S_IDLE || st == S_ZT || st == S_OUT);
  assign u_start    = unit_state && !launched;

  // signed Q16 product, rounded with halves up
  always_comb begin
    prod_s   = mv[32] ? -$signed({2'b00, u_res}) : $signed({2'b00, u_res});
    q16      = (prod_s + 67'sd32768) >>> 16;
    root_val = u_res[31:0];
    w_sum    = $signed({36'd0, weight_est}) + q16;
    if (w_sum < 0) w_new = '0;
    else if (w_sum > $signed({36'd0, max_weight})) w_new = max_weight;
    else w_new = w_sum[30:0];
    missing  = (expected_weight > weight_est) ? expected_weight - weight_est : '0;
    z_sum    = sat32(67'(attr_z) + q16);
    z_lo     = (z_sum < z_level) ? z_level : z_sum;
  end

  assign in_ready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= S_IDLE;
      launched        <= 1'b0;
      out_valid       <= 1'b0;
      expected_weight <= 31'd642253;
      max_weight      <= 31'd655360;
      z_top           <= 32'sd19661;
      z_level         <= 32'sd6554;
      share_trigger   <= 17'd52429;
      share_final     <= 17'd62259;
      share_contact   <= 17'd13107;
      weight_est      <= '0;
      share_est       <= '0;
      attr_x          <= REST_X;
      attr_y          <= REST_Y;
      attr_z          <= REST_Z;
      hold_x          <= REST_X;
      hold_y          <= REST_Y;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_EXPECTED: expected_weight <= cfg_data[30:0];
          REG_MAXW:     max_weight      <= cfg_data[30:0];
          REG_CEILING:  z_top           <= cfg_data;
          REG_LEVEL:    z_level         <= cfg_data;
          REG_TRIGGER:  share_trigger   <= cfg_data[16:0];
          REG_FINAL:    share_final     <= cfg_data[16:0];
          REG_CONTACT:  share_contact   <= cfg_data[16:0];
          default: ;
        endcase
      end
      // load a new beat or drop the one just taken
      if (st == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (u_start) launched <= 1'b1;
      if (u_done)  launched <= 1'b0;

      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            inr       <= in_data;
            held_prev <= share_est > share_contact;
            if (in_data.object_seen) begin
              st <= S_SQA;
            end else begin
              obj_dist <= DIST_NONE;
              stat     <= ST_NO_MARKER;
              st       <= S_WGT;
            end
          end
        end
        S_SQA: if (u_done) begin tmp <= u_res[63:0]; st <= S_SQB; end
        S_SQB: if (u_done) begin tmp <= tmp + u_res[63:0]; st <= S_ROOTD; end
        S_ROOTD: if (u_done) begin
          obj_dist <= root_val;
          if (root_val > DIST_FAR) begin
            // too far: drift back to rest
            mv_tx   <= REST_X;
            mv_ty   <= REST_Y;
            mv_gain <= GAIN_FAR;
            stat    <= held_prev ? ST_MARKER_FAR : ST_TOO_FAR;
            st      <= S_AX;
          end else begin
            if (inr.base_pos_ok) begin
              hold_x <= inr.object_x;
              hold_y <= inr.object_y;
            end
            if (root_val < DIST_NEAR) begin
              if (held_prev) begin
                mv_tx   <= REST_X;
                mv_ty   <= REST_Y;
                mv_gain <= GAIN_HOLD;
                stat    <= ST_HOLDING;
                st      <= S_AX;
              end else begin
                stat <= ST_UNDER;
                st   <= S_WGT;
              end
            end else begin
              // near: pull toward the held object position
              mv_tx   <= inr.base_pos_ok ? inr.object_x : hold_x;
              mv_ty   <= inr.base_pos_ok ? inr.object_y : hold_y;
              mv_gain <= GAIN_FAR;
              stat    <= held_prev ? ST_CARRYING : ST_COMING;
              st      <= S_AX;
            end
          end
        end
        S_AX: if (u_done) begin attr_x <= sat32(67'(attr_x) + q16); st <= S_AY; end
        S_AY: if (u_done) begin attr_y <= sat32(67'(attr_y) + q16); st <= S_WGT; end
        S_WGT: if (u_done) begin
          weight_est <= w_new;
          if (expected_weight == '0) begin
            share_est <= (w_new != '0) ? ONE_Q16 : '0;
            st        <= S_SQFX;
          end else begin
            st <= S_SHR;
          end
        end
        S_SHR: if (u_done) begin
          share_est <= (u_res > 65'(ONE_Q16)) ? ONE_Q16 : u_res[16:0];
          st        <= S_SQFX;
        end
        S_SQFX: if (u_done) begin tmp <= u_res[63:0]; st <= S_SQFY; end
        S_SQFY: if (u_done) begin tmp <= tmp + u_res[63:0]; st <= S_ROOTS; end
        S_ROOTS: if (u_done) begin
          side <= root_val;
          if (root_val > {1'b0, missing}) begin
            st <= S_DZMX;
          end else begin
            dx <= sat32(-67'(inr.force_x));
            dy <= sat32(-67'(inr.force_y));
            st <= S_ZT;
          end
        end
        S_DZMX: if (u_done) begin tmp <= u_res[63:0]; st <= S_DZDX; end
        S_DZDX: if (u_done) begin
          dx <= sat32(inr.force_x[31] ? $signed({3'b000, u_res[63:0]})
                                      : -$signed({3'b000, u_res[63:0]}));
          st <= S_DZMY;
        end
        S_DZMY: if (u_done) begin tmp <= u_res[63:0]; st <= S_DZDY; end
        S_DZDY: if (u_done) begin
          dy <= sat32(inr.force_y[31] ? $signed({3'b000, u_res[63:0]})
                                      : -$signed({3'b000, u_res[63:0]}));
          st <= S_ZT;
        end
        S_ZT: begin
          tgt <= (obj_dist > DIST_HIGH) ? REST_Z : z_top;
          if (share_est > share_trigger) begin
            if (share_final > share_trigger) begin
              st <= S_BDIV;
            end else begin
              beta <= ONE_Q16;
              st   <= S_BMUL;
            end
          end else begin
            st <= S_ZM;
          end
        end
        S_BDIV: if (u_done) begin
          beta <= (u_res > 65'(ONE_Q16)) ? ONE_Q16 : u_res[16:0];
          st   <= S_BMUL;
        end
        S_BMUL: if (u_done) begin tgt <= sat32(67'(z_top) + q16); st <= S_ZM; end
        S_ZM: if (u_done) begin
          attr_z <= (z_lo > z_top) ? z_top : z_lo;
          st     <= S_OUT;
        end
        S_OUT: begin
          // hold the beat until the previous result is taken
          if (!out_valid || out_ready) begin
            out_data.drive_x   <= dx;
            out_data.drive_y   <= dy;
            out_data.drive_z   <= $signed({1'b0, weight_est});
            out_data.target_x  <= attr_x;
            out_data.target_y  <= attr_y;
            out_data.target_z  <= attr_z;
            out_data.share_out <= share_est;
            out_data.status    <= stat;
            st                 <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_done_launched: assert property (@(posedge clk) disable iff (rst)
    u_done |-> launched) else $error("unit result without a launch");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> st != S_IDLE) else $error("tick accepted but sequencer idle");
  a_share_range: assert property (@(posedge clk) disable iff (rst)
    share_est <= ONE_Q16) else $error("load share above one");
  a_out_leaves: assert property (@(posedge clk) disable iff (rst)
    st == S_OUT && !out_valid |=> out_valid && st == S_IDLE) else $error("result not loaded");

endmodule

// ===== src/lsfa_unit.sv =====
module lsfa_unit import lsfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  unit_op_t    op,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [64:0] result
);

  logic [63:0] x;
  logic [64:0] y;
  logic [65:0] r;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic        busy;
  unit_op_t    op_q;

  logic [33:0] div_rr;
  logic        div_bit;
  logic [35:0] rt_rr;
  logic [35:0] rt_trial;
  logic        rt_bit;

  always_comb begin
    div_rr   = {r[32:0], x[63]};
    div_bit  = div_rr >= {2'b00, d};
    rt_rr    = {r[33:0], x[63:62]};
    rt_trial = {1'b0, y[32:0], 2'b01};
    rt_bit   = rt_rr >= rt_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        op_q <= op;
        d    <= b;
        y    <= '0;
        unique case (op)
          OP_MUL: begin
            r   <= {2'b00, a};
            x   <= {32'd0, b};
            cnt <= 6'd31;
          end
          OP_DIV: begin
            r   <= '0;
            x   <= a;
            cnt <= 6'd63;
          end
          default: begin
            r   <= '0;
            x   <= a;
            cnt <= 6'd31;
          end
        endcase
      end else if (busy) begin
        case (op_q)
          OP_MUL: begin
            if (x[0]) y <= y + r[64:0];
            r <= {r[64:0], 1'b0};
            x <= {1'b0, x[63:1]};
          end
          OP_DIV: begin
            r <= div_bit ? {32'd0, div_rr - {2'b00, d}} : {32'd0, div_rr};
            x <= {x[62:0], div_bit};
          end
          default: begin
            r <= rt_bit ? {30'd0, rt_rr - rt_trial} : {30'd0, rt_rr};
            y <= {y[63:0], rt_bit};
            x <= {x[61:0], 2'b00};
          end
        endcase
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = (op_q == OP_DIV) ? {1'b0, x} : y;

endmodule
